[design/swtsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window target sum counter package
// Shared widths, default parameter values and the sequencer state encoding.
// ----------------------------------------------------------------------------
package swtsc_pkg;

  localparam int unsigned WindowDepthDefault = 1024;
  localparam int unsigned ValueBitsDefault   = 32;

  localparam int unsigned SampleW = 32;
  localparam int unsigned TargetW = 48;
  localparam int unsigned TotalW  = 49;
  localparam int unsigned CountW  = 32;

  localparam logic [TargetW-1:0] TargetReset = TargetW'(1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVICT = 5'b00010,
    ST_PUSH  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_POP   = 5'b10000
  } state_e;

endpackage
`default_nettype wire

[design/sliding_window_target_sum_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window target sum counter
// Counts contiguous runs of a value stream whose sum equals a target, with a
// two-pointer window held in a FIFO memory and one shared adder/comparator.
// ----------------------------------------------------------------------------
// Sequence: an item goes through EVICT (only when the window is full), PUSH, then
// CHECK and POP in turn; the result register loads from the last CHECK.
// Throughput: one item at a time; input stall stays high until the result is
// registered, the output register lets the next item start while it waits.
// Reset: control state, pointers, total and counters clear and the target
// returns to 1; the FIFO memory is not cleared.
module sliding_window_target_sum_counter #(
  parameter int unsigned WINDOW_DEPTH = swtsc_pkg::WindowDepthDefault,
  parameter int unsigned VALUE_BITS   = swtsc_pkg::ValueBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [swtsc_pkg::TargetW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [swtsc_pkg::SampleW-1:0] sample_value_i,
  input  wire logic                          end_of_sequence_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [swtsc_pkg::CountW-1:0]       match_count_o,
  output logic                               window_overflow_o,
  output logic                               final_result_o
);

  localparam int unsigned StoreW = (VALUE_BITS < swtsc_pkg::SampleW) ?
                                   VALUE_BITS : swtsc_pkg::SampleW;
  localparam int unsigned PtrW   = $clog2(WINDOW_DEPTH);
  localparam int unsigned OccW   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TotalW = swtsc_pkg::TotalW;
  localparam int unsigned CountW = swtsc_pkg::CountW;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_DEPTH - 1);
  localparam logic [OccW-1:0] OccFull = OccW'(WINDOW_DEPTH);

  logic [StoreW-1:0] fifo_mem [WINDOW_DEPTH];
  logic [StoreW-1:0] rd_data_q;

  swtsc_pkg::state_e state_q, state_d;

  logic [swtsc_pkg::TargetW-1:0] target_q;
  logic [TotalW-1:0]             total_q, total_d;
  logic [PtrW-1:0]               head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]               occ_q, occ_d;
  logic [CountW-1:0]             count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic [StoreW-1:0]             sample_q;
  logic                          last_q;

  logic                          out_valid_q;
  logic [CountW-1:0]             out_count_q;
  logic                          out_ovf_q;
  logic                          out_last_q;

  logic                          in_fire;
  logic                          slot_free;
  logic                          load_out;
  logic                          mem_we;
  logic [StoreW-1:0]             operand;
  logic [TotalW-1:0]             alu_sum;
  logic                          total_ge;
  logic                          total_eq;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != swtsc_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && (state_q == swtsc_pkg::ST_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;

  // Shared add/subtract unit and comparator.
  assign operand  = (state_q == swtsc_pkg::ST_PUSH) ? sample_q : rd_data_q;
  assign alu_sum  = (state_q == swtsc_pkg::ST_PUSH) ?
                    total_q + TotalW'(operand) : total_q - TotalW'(operand);
  assign total_ge = total_q >= TotalW'(target_q);
  assign total_eq = total_q == TotalW'(target_q);

  assign mem_we   = (state_q == swtsc_pkg::ST_PUSH);
  assign load_out = (state_q == swtsc_pkg::ST_CHECK) &&
                    !((occ_q != '0) && total_ge) && slot_free;

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    head_d  = head_q;
    tail_d  = tail_q;
    occ_d   = occ_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      swtsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (occ_q == OccFull) begin
            ovf_d   = 1'b1;
            state_d = swtsc_pkg::ST_EVICT;
          end else begin
            state_d = swtsc_pkg::ST_PUSH;
          end
        end
      end
      swtsc_pkg::ST_EVICT: begin
        total_d = alu_sum;
        head_d  = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
        occ_d   = occ_q - OccW'(1);
        state_d = swtsc_pkg::ST_PUSH;
      end
      swtsc_pkg::ST_PUSH: begin
        total_d = alu_sum;
        tail_d  = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
        occ_d   = occ_q + OccW'(1);
        state_d = swtsc_pkg::ST_CHECK;
      end
      swtsc_pkg::ST_CHECK: begin
        if ((occ_q != '0) && total_ge) begin
          if (total_eq && (count_q != '1)) begin
            count_d = count_q + CountW'(1);
          end
          state_d = swtsc_pkg::ST_POP;
        end else if (slot_free) begin
          if (last_q) begin
            total_d = '0;
            head_d  = '0;
            tail_d  = '0;
            occ_d   = '0;
            count_d = '0;
            ovf_d   = 1'b0;
          end
          state_d = swtsc_pkg::ST_IDLE;
        end
      end
      swtsc_pkg::ST_POP: begin
        total_d = alu_sum;
        head_d  = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
        occ_d   = occ_q - OccW'(1);
        state_d = swtsc_pkg::ST_CHECK;
      end
      default: begin
        state_d = swtsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swtsc_pkg::ST_IDLE;
      target_q    <= swtsc_pkg::TargetReset;
      total_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cfg_valid_i) begin
        target_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_value_i[StoreW-1:0];
      last_q   <= end_of_sequence_i;
    end
    if (load_out) begin
      out_count_q <= count_q;
      out_ovf_q   <= ovf_q;
      out_last_q  <= last_q;
    end
  end

  // The head entry is read every cycle; the read data serves the next step.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fifo_mem[tail_q] <= sample_q;
    end
    rd_data_q <= fifo_mem[head_q];
  end

  assign out_valid_o       = out_valid_q;
  assign match_count_o     = out_count_q;
  assign window_overflow_o = out_ovf_q;
  assign final_result_o    = out_last_q;

endmodule
`default_nettype wire
